/* hw/rtl/dss_pkg.sv */
// shared types and codes for the dual stack block
package dss_pkg;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_PEEK    = 2'd2,
        OP_DISPLAY = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DISP = 1'b1
    } state_t;

    // command to one chain of cells
    typedef struct packed {
        logic push;
        logic pop;
        logic rot;
    } chain_cmd_t;

    // per cell shift control
    typedef struct packed {
        logic shift_dn;
        logic shift_up;
        logic wrap;
    } cell_ctrl_t;

    localparam int unsigned OUT_WIDTH = 32;

endpackage

/* hw/rtl/dss_cell.sv */
// one storage cell of a shift-register stack
module dss_cell #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                   aclk,
    input  dss_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0]  prev_data,
    input  logic [DATA_WIDTH-1:0]  next_data,
    input  logic [DATA_WIDTH-1:0]  head_data,
    output logic [DATA_WIDTH-1:0]  data
);
    import dss_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_dn) begin
            data_next = prev_data;
        end else if (ctrl.shift_up) begin
            data_next = ctrl.wrap ? head_data : next_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* hw/rtl/dss_chain.sv */
// row of cells forming one stack, top element in cell zero
module dss_chain #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                   aclk,
    input  dss_pkg::chain_cmd_t    cmd,
    input  logic [CNT_W-1:0]       count,
    input  logic [DATA_WIDTH-1:0]  push_data,
    output logic [DATA_WIDTH-1:0]  head_data
);
    import dss_pkg::*;

    logic [DATA_WIDTH-1:0] cell_q [DEPTH];
    cell_ctrl_t            cell_ctrl [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic [DATA_WIDTH-1:0] prev_d;
            logic [DATA_WIDTH-1:0] next_d;

            if (i == 0) begin : g_first
                assign prev_d = push_data;
            end else begin : g_mid
                assign prev_d = cell_q[i-1];
            end

            if (i == DEPTH - 1) begin : g_last
                assign next_d = cell_q[i];
            end else begin : g_body
                assign next_d = cell_q[i+1];
            end

            always_comb begin
                cell_ctrl[i].shift_dn = cmd.push;
                cell_ctrl[i].shift_up = cmd.pop | cmd.rot;
                cell_ctrl[i].wrap     = cmd.rot && (CNT_W'(i) + CNT_W'(1) == count);
            end

            dss_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl[i]),
                .prev_data (prev_d),
                .next_data (next_d),
                .head_data (cell_q[0]),
                .data      (cell_q[i])
            );
        end
    endgenerate

    assign head_data = cell_q[0];

endmodule

/* hw/rtl/dual_stack_shared_array.sv */
// top level: two stacks, each a chain of cells, behind one stream interface
//
//  channel  | direction | transaction
//  ---------+-----------+------------------------------------------------
//  s_       | in        | opcode, stack select, push value
//  m_       | out       | status, element, last of the run
//
// push, pop and peek each return one result; display returns one result per
// stored element (or one empty status), made by rotating the chosen chain of
// cells by one cell per result.
// a new transaction is taken only between operations, while the output
// register is empty or being drained.
// reset clears both counts and the control; cell contents are not reset.
// a stall on m_ freezes the display rotation until the result is taken.
module dual_stack_shared_array #(
    parameter int unsigned TOTAL_DEPTH = 32,
    parameter int unsigned DATA_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // push_value
    input  logic [2:0]  s_tuser,   // opcode[1:0], stack_sel[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_out
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast
);
    import dss_pkg::*;

    localparam int unsigned HALF_DEPTH = TOTAL_DEPTH / 2;
    localparam int unsigned CNT_W      = $clog2(HALF_DEPTH + 1);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      lower_count_reg, lower_count_next;
    logic [CNT_W-1:0]      upper_count_reg, upper_count_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic                  sel_reg, sel_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [OUT_WIDTH-1:0]  m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;

    chain_cmd_t            lower_cmd, upper_cmd;
    logic [DATA_WIDTH-1:0] lower_head, upper_head;
    logic [DATA_WIDTH-1:0] push_data;

    opcode_t               in_op;
    logic                  in_sel;
    logic                  out_free;
    logic                  accept;
    logic [CNT_W-1:0]      in_count;
    logic [DATA_WIDTH-1:0] in_head;
    logic [DATA_WIDTH-1:0] disp_head;
    chain_cmd_t            cmd;

    assign in_op     = opcode_t'(s_tuser[1:0]);
    assign in_sel    = s_tuser[2];
    assign push_data = DATA_WIDTH'(s_tdata);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign in_count  = in_sel ? upper_count_reg : lower_count_reg;
    assign in_head   = in_sel ? upper_head : lower_head;
    assign disp_head = sel_reg ? upper_head : lower_head;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && in_op == OP_DISPLAY && in_count != '0) begin
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                if (out_free && rem_reg == CNT_W'(1)) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        lower_count_next = lower_count_reg;
        upper_count_next = upper_count_reg;
        rem_next         = rem_reg;
        sel_next         = sel_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;
        cmd              = '0;
        lower_cmd        = '0;
        upper_cmd        = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_data_next = '0;
                    m_last_next = 1'b1;
                    sel_next    = in_sel;
                    case (in_op)
                        OP_PUSH: begin
                            m_valid_next = 1'b1;
                            if (in_count == CNT_W'(HALF_DEPTH)) begin
                                m_status_next = STAT_OVERFLOW;
                            end else begin
                                m_status_next = STAT_OK;
                                cmd.push      = 1'b1;
                                if (in_sel) begin
                                    upper_count_next = upper_count_reg + CNT_W'(1);
                                end else begin
                                    lower_count_next = lower_count_reg + CNT_W'(1);
                                end
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            m_valid_next = 1'b1;
                            if (in_count == '0) begin
                                m_status_next = STAT_EMPTY;
                            end else begin
                                m_status_next = STAT_OK;
                                m_data_next   = OUT_WIDTH'($signed(in_head));
                                if (in_op == OP_POP) begin
                                    cmd.pop = 1'b1;
                                    if (in_sel) begin
                                        upper_count_next = upper_count_reg - CNT_W'(1);
                                    end else begin
                                        lower_count_next = lower_count_reg - CNT_W'(1);
                                    end
                                end
                            end
                        end
                        OP_DISPLAY: begin
                            if (in_count == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_EMPTY;
                            end else begin
                                rem_next = in_count;
                            end
                        end
                        default: m_valid_next = 1'b0;
                    endcase
                    if (in_sel) begin
                        upper_cmd = cmd;
                    end else begin
                        lower_cmd = cmd;
                    end
                end
            end
            S_DISP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_data_next   = OUT_WIDTH'($signed(disp_head));
                    m_last_next   = (rem_reg == CNT_W'(1));
                    rem_next      = rem_reg - CNT_W'(1);
                    cmd.rot       = 1'b1;
                    if (sel_reg) begin
                        upper_cmd = cmd;
                    end else begin
                        lower_cmd = cmd;
                    end
                end
            end
            default: m_valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            lower_count_reg <= '0;
            upper_count_reg <= '0;
            rem_reg         <= '0;
            sel_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            lower_count_reg <= lower_count_next;
            upper_count_reg <= upper_count_next;
            rem_reg         <= rem_next;
            sel_reg         <= sel_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
    end

    dss_chain #(
        .DEPTH      (HALF_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_lower (
        .aclk      (aclk),
        .cmd       (lower_cmd),
        .count     (lower_count_reg),
        .push_data (push_data),
        .head_data (lower_head)
    );

    dss_chain #(
        .DEPTH      (HALF_DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_upper (
        .aclk      (aclk),
        .cmd       (upper_cmd),
        .count     (upper_count_reg),
        .push_data (push_data),
        .head_data (upper_head)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* bench/dual_stack_shared_array_test.sv */
// testbench for the dual stack block: directed table, then random checked by a predictor
module dual_stack_shared_array_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    localparam int unsigned DEPTH = 32;
    localparam int unsigned WIDTH = 32;
    localparam int unsigned HALF  = DEPTH / 2;
    localparam int unsigned N_DIRECTED = 23;
    localparam int unsigned N_RANDOM   = 200;

    typedef struct packed {
        opcode_t     op;
        logic        sel;
        logic [31:0] value;
        logic        typed;
        status_t     t_status;
        logic [31:0] t_data;
    } stack_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] data;
        logic        last;
    } stack_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // push_value
    logic [2:0]  s_tuser;   // opcode[1:0], stack_sel[2]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // data_out
    logic [1:0]  m_tuser;   // status
    logic        m_tlast;

    stack_cmd_t    cur_cmd;
    stack_cmd_t    directed_rows [N_DIRECTED];
    stack_cmd_t    random_q[$];
    stack_result_t expected_q[$];
    stack_result_t op_results[$];

    logic [WIDTH-1:0] shadow_mem [DEPTH];
    int unsigned      lower_cnt;
    int unsigned      upper_cnt;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches;

    dual_stack_shared_array #(
        .TOTAL_DEPTH(DEPTH),
        .DATA_WIDTH (WIDTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic stack_result_t mk_result(status_t st, logic [31:0] d, logic l);
        stack_result_t r;
        r.status = st;
        r.data   = d;
        r.last   = l;
        return r;
    endfunction

    function automatic stack_cmd_t mk_cmd(opcode_t op, logic sel, logic [31:0] v);
        stack_cmd_t c;
        c = '0;
        c.op    = op;
        c.sel   = sel;
        c.value = v;
        return c;
    endfunction

    function automatic stack_cmd_t mk_typed(opcode_t op, logic sel, logic [31:0] v,
                                            status_t st, logic [31:0] d);
        stack_cmd_t c;
        c = mk_cmd(op, sel, v);
        c.typed    = 1'b1;
        c.t_status = st;
        c.t_data   = d;
        return c;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // store index of the k-th element below the top
    function automatic int unsigned stack_slot(logic sel, int unsigned cnt, int unsigned k);
        return sel ? DEPTH - cnt + k : cnt - 1 - k;
    endfunction

    // applies one operation to the shadow stacks and collects its results
    task automatic apply_stack_op(input opcode_t op, input logic sel, input logic [31:0] val);
        int unsigned n;
        n = sel ? upper_cnt : lower_cnt;
        op_results.delete();
        if (op == OP_PUSH) begin
            if (n >= HALF) begin
                op_results.push_back(mk_result(STAT_OVERFLOW, 32'h0, 1'b1));
            end else begin
                n++;
                shadow_mem[stack_slot(sel, n, 0)] = val[WIDTH-1:0];
                op_results.push_back(mk_result(STAT_OK, 32'h0, 1'b1));
            end
        end else if (n == 0) begin
            op_results.push_back(mk_result(STAT_EMPTY, 32'h0, 1'b1));
        end else if (op == OP_DISPLAY) begin
            for (int unsigned k = 0; k < n; k++)
                op_results.push_back(mk_result(STAT_OK, shadow_mem[stack_slot(sel, n, k)],
                                               k + 1 == n));
        end else begin
            op_results.push_back(mk_result(STAT_OK, shadow_mem[stack_slot(sel, n, 0)], 1'b1));
            if (op == OP_POP)
                n--;
        end
        if (sel)
            upper_cnt = n;
        else
            lower_cnt = n;
    endtask

    always @(posedge aclk) begin
        stack_result_t got;
        stack_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                apply_stack_op(opcode_t'(s_tuser[1:0]), s_tuser[2], s_tdata);
                if (cur_cmd.typed)
                    expected_q.push_back(mk_result(cur_cmd.t_status, cur_cmd.t_data, 1'b1));
                else
                    foreach (op_results[j])
                        expected_q.push_back(op_results[j]);
            end
            if (m_tvalid && m_tready) begin
                got = mk_result(status_t'(m_tuser), m_tdata, m_tlast);
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: status %0d data %h last %0b",
                                 got.status, got.data, got.last);
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.data !== want.data ||
                        got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %h %0b, got %0d %h %0b",
                                     want.status, want.data, want.last,
                                     got.status, got.data, got.last);
                    end
                end
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_cmd(input stack_cmd_t cmd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cmd.value;
        s_tuser  <= {cmd.sel, cmd.op};
        cur_cmd  <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin
        stack_cmd_t  cmd;
        int unsigned len;
        int unsigned kind;
        logic        sel;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cur_cmd   <= '0;
        aresetn   <= 1'b0;
        lower_cnt = 0;
        upper_cnt = 0;
        mismatches = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        directed_rows[0]  = mk_typed(OP_POP,     1'b0, 32'h0, STAT_EMPTY, 32'h0);
        directed_rows[1]  = mk_typed(OP_PEEK,    1'b1, 32'h0, STAT_EMPTY, 32'h0);
        directed_rows[2]  = mk_typed(OP_DISPLAY, 1'b0, 32'h0, STAT_EMPTY, 32'h0);
        directed_rows[3]  = mk_typed(OP_DISPLAY, 1'b1, 32'h0, STAT_EMPTY, 32'h0);
        directed_rows[4]  = mk_typed(OP_POP,     1'b1, 32'hffff_ffff, STAT_EMPTY, 32'h0);
        directed_rows[5]  = mk_typed(OP_PUSH,    1'b0, 32'h7fff_ffff, STAT_OK, 32'h0);
        directed_rows[6]  = mk_typed(OP_PUSH,    1'b0, 32'h8000_0000, STAT_OK, 32'h0);
        directed_rows[7]  = mk_typed(OP_PEEK,    1'b0, 32'h0, STAT_OK, 32'h8000_0000);
        directed_rows[8]  = mk_typed(OP_PUSH,    1'b1, 32'hffff_ffff, STAT_OK, 32'h0);
        directed_rows[9]  = mk_typed(OP_PUSH,    1'b1, 32'h0000_0000, STAT_OK, 32'h0);
        directed_rows[10] = mk_typed(OP_PUSH,    1'b1, 32'ha5a5_a5a5, STAT_OK, 32'h0);
        directed_rows[11] = mk_cmd(OP_DISPLAY,   1'b1, 32'h0);
        directed_rows[12] = mk_cmd(OP_DISPLAY,   1'b0, 32'h0);
        directed_rows[13] = mk_typed(OP_POP,     1'b0, 32'h0, STAT_OK, 32'h8000_0000);
        directed_rows[14] = mk_typed(OP_POP,     1'b0, 32'h0, STAT_OK, 32'h7fff_ffff);
        directed_rows[15] = mk_typed(OP_POP,     1'b0, 32'h0, STAT_EMPTY, 32'h0);
        directed_rows[16] = mk_typed(OP_PEEK,    1'b1, 32'h0, STAT_OK, 32'ha5a5_a5a5);
        directed_rows[17] = mk_cmd(OP_POP,       1'b1, 32'h0);
        directed_rows[18] = mk_typed(OP_PUSH,    1'b0, 32'h5a5a_5a5a, STAT_OK, 32'h0);
        directed_rows[19] = mk_cmd(OP_DISPLAY,   1'b0, 32'h0);
        directed_rows[20] = mk_cmd(OP_POP,       1'b1, 32'h0);
        directed_rows[21] = mk_cmd(OP_POP,       1'b1, 32'h0);
        directed_rows[22] = mk_typed(OP_POP,     1'b1, 32'h0, STAT_EMPTY, 32'h0);

        // first a fill past full so overflow is always reached
        sel = 1'($urandom_range(0, 1));
        for (int unsigned i = 0; i < HALF + 2; i++)
            random_q.push_back(mk_cmd(OP_PUSH, sel, rand_word()));
        random_q.push_back(mk_cmd(OP_DISPLAY, sel, rand_word()));
        while (random_q.size() < N_RANDOM) begin
            sel  = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 4);
            case (kind)
                0, 1: begin
                    len = $urandom_range(1, HALF + 1);
                    for (int unsigned i = 0; i < len; i++)
                        random_q.push_back(mk_cmd(OP_PUSH, sel, rand_word()));
                    random_q.push_back(mk_cmd(OP_DISPLAY, sel, rand_word()));
                end
                2: begin
                    len = $urandom_range(1, HALF + 1);
                    for (int unsigned i = 0; i < len; i++)
                        random_q.push_back(mk_cmd($urandom_range(0, 3) == 0 ? OP_PEEK : OP_POP,
                                                  sel, rand_word()));
                end
                default: begin
                    len = $urandom_range(3, 8);
                    for (int unsigned i = 0; i < len; i++)
                        random_q.push_back(mk_cmd(opcode_t'($urandom_range(0, 3)),
                                                  1'($urandom_range(0, 1)), rand_word()));
                end
            endcase
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int unsigned i = 0; i < N_DIRECTED; i++)
            send_cmd(directed_rows[i]);

        foreach (random_q[i]) begin
            case (i * 4 / random_q.size())
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 61;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 61;
                end
                default: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            send_cmd(random_q[i]);
        end
        s_tvalid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("[dual_stack_shared_array] OK");
        end else begin
            $display("[dual_stack_shared_array] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[dual_stack_shared_array] ERROR");
        $finish;
    end

endmodule
